FILE: hw/rtl/cna_pkg.sv
// Shared types and constants of the complex arithmetic unit.
package cna_pkg;

   // Remainder width: divisor shifted by the top quotient bit position
   localparam int RW = 97;
   // Quotient width: 33 quotient bits plus room for the rounding increment
   localparam int QW = 34;

   localparam logic [QW-1:0] Q_MAX_POS = 34'h0_7FFF_FFFF;
   localparam logic [QW-1:0] Q_MAX_NEG = 34'h0_8000_0000;

   typedef enum logic [2:0] {
      FUNC_ADD   = 3'd0,
      FUNC_SUB   = 3'd1,
      FUNC_MUL   = 3'd2,
      FUNC_SCALE = 3'd3,
      FUNC_DIVC  = 3'd4,
      FUNC_DIVR  = 3'd5,
      FUNC_CMP   = 3'd6
   } func_type;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] a_real;
      logic signed [31:0] a_imag;
      logic signed [31:0] b_real;
      logic signed [31:0] b_imag;
      logic signed [31:0] scalar;
   } op_type;

   typedef struct packed {
      func_type           func;
      logic signed [63:0] p0;
      logic signed [63:0] p1;
      logic signed [63:0] p2;
      logic signed [63:0] p3;
      logic signed [63:0] p4;
      logic signed [63:0] p5;
      logic signed [32:0] s_real;
      logic signed [32:0] s_imag;
      logic signed [31:0] a_real;
      logic signed [31:0] a_imag;
      logic signed [31:0] scalar;
   } prod_type;

   typedef struct packed {
      logic        neg;
      logic [63:0] mag;
   } part_type;

   typedef struct packed {
      func_type    func;
      part_type    re;
      part_type    im;
      logic [63:0] dvsr;
   } comb_type;

   typedef struct packed {
      logic          neg;
      logic          ovf;
      logic [RW-1:0] rem;
      logic [QW-1:0] quo;
   } dpart_type;

   typedef struct packed {
      logic        is_div;
      logic        eq;
      logic        err;
      logic [63:0] dvsr;
      dpart_type   re;
      dpart_type   im;
   } div_type;

   typedef struct packed {
      logic signed [31:0] res_real;
      logic signed [31:0] res_imag;
      logic               equal_flag;
      logic               div_error;
      logic               saturated;
   } rsp_type;

endpackage

FILE: hw/rtl/cna_req_if.sv
// Operation request channel.
interface cna_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         func;
   logic signed [31:0] a_real;
   logic signed [31:0] a_imag;
   logic signed [31:0] b_real;
   logic signed [31:0] b_imag;
   logic signed [31:0] scalar;

   modport source (output valid, func, a_real, a_imag, b_real, b_imag, scalar,
                   input ready);
   modport sink   (input valid, func, a_real, a_imag, b_real, b_imag, scalar,
                   output ready);
endinterface

FILE: hw/rtl/cna_rsp_if.sv
// Result channel.
interface cna_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] res_real;
   logic signed [31:0] res_imag;
   logic               equal_flag;
   logic               div_error;
   logic               saturated;

   modport source (output valid, res_real, res_imag, equal_flag, div_error, saturated,
                   input ready);
   modport sink   (input valid, res_real, res_imag, equal_flag, div_error, saturated,
                   output ready);
endinterface

FILE: hw/rtl/cna_csr_if.sv
// Tolerance register write channel.
interface cna_csr_if;
   logic        valid;
   logic        ready;
   logic [30:0] tolerance;

   modport source (output valid, tolerance, input ready);
   modport sink   (input valid, tolerance, output ready);
endinterface

FILE: hw/rtl/cna_mult.sv
// First stage: operand products and sums/differences.
module cna_mult (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cna_pkg::op_type   in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output cna_pkg::prod_type out_data
);
   import cna_pkg::*;

   logic     valid_ff;
   prod_type data_ff;
   prod_type data_in;
   func_type fn;
   logic signed [31:0] y_re;

   assign fn = func_type'(in_data.func);

   // Form the products; scale swaps the real scalar in for b_real
   always_comb begin
      y_re            = (fn == FUNC_SCALE) ? in_data.scalar : in_data.b_real;
      data_in.func    = fn;
      data_in.p0      = in_data.a_real * y_re;
      data_in.p1      = in_data.a_imag * in_data.b_imag;
      data_in.p2      = in_data.a_real * in_data.b_imag;
      data_in.p3      = in_data.a_imag * y_re;
      data_in.p4      = in_data.b_real * in_data.b_real;
      data_in.p5      = in_data.b_imag * in_data.b_imag;
      if (fn == FUNC_ADD) begin
         data_in.s_real = 33'(in_data.a_real) + 33'(in_data.b_real);
         data_in.s_imag = 33'(in_data.a_imag) + 33'(in_data.b_imag);
      end else begin
         data_in.s_real = 33'(in_data.a_real) - 33'(in_data.b_real);
         data_in.s_imag = 33'(in_data.a_imag) - 33'(in_data.b_imag);
      end
      data_in.a_real  = in_data.a_real;
      data_in.a_imag  = in_data.a_imag;
      data_in.scalar  = in_data.scalar;
   end

   assign in_ready = !valid_ff || out_ready;

   // Advance when the next stage has room
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

FILE: hw/rtl/cna_combine.sv
// Second stage: combine products into signed numerators and the divisor.
module cna_combine (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cna_pkg::prod_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output cna_pkg::comb_type out_data
);
   import cna_pkg::*;

   logic     valid_ff;
   comb_type data_ff;
   comb_type data_in;
   part_type sc_sm;

   function automatic part_type to_sm(logic signed [64:0] v);
      part_type r;
      r.neg = v[64];
      r.mag = v[64] ? 64'(-v) : 64'(v);
      return r;
   endfunction

   // Select the numerators for each operation
   always_comb begin
      sc_sm        = to_sm(65'(in_data.scalar));
      data_in.func = in_data.func;
      data_in.re   = '0;
      data_in.im   = '0;
      data_in.dvsr = '0;
      case (in_data.func) inside
         FUNC_ADD, FUNC_SUB, FUNC_CMP: begin
            data_in.re = to_sm(65'(in_data.s_real));
            data_in.im = to_sm(65'(in_data.s_imag));
         end
         FUNC_MUL: begin
            data_in.re = to_sm(65'(in_data.p0) - 65'(in_data.p1));
            data_in.im = to_sm(65'(in_data.p2) + 65'(in_data.p3));
         end
         FUNC_SCALE: begin
            data_in.re = to_sm(65'(in_data.p0));
            data_in.im = to_sm(65'(in_data.p3));
         end
         FUNC_DIVC: begin
            data_in.re   = to_sm(65'(in_data.p0) + 65'(in_data.p1));
            data_in.im   = to_sm(65'(in_data.p3) - 65'(in_data.p2));
            data_in.dvsr = 64'(in_data.p4) + 64'(in_data.p5);
         end
         FUNC_DIVR: begin
            data_in.re     = to_sm(65'(in_data.a_real));
            data_in.im     = to_sm(65'(in_data.a_imag));
            data_in.re.neg = data_in.re.neg ^ sc_sm.neg;
            data_in.im.neg = data_in.im.neg ^ sc_sm.neg;
            data_in.dvsr   = sc_sm.mag;
         end
         default: begin
            data_in.re = '0;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

FILE: hw/rtl/cna_prep.sv
// Third stage: divisor and tolerance tests, quotient setup, product rescale.
module cna_prep #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [30:0]       tolerance,
   input  logic              in_valid,
   output logic              in_ready,
   input  cna_pkg::comb_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output cna_pkg::div_type  out_data
);
   import cna_pkg::*;

   logic        valid_ff;
   div_type     data_ff;
   div_type     data_in;
   logic [63:0] thr;
   logic        is_dv;
   logic        err;

   function automatic dpart_type prep_part(part_type p, func_type f, logic dv,
                                           logic [63:0] d);
      dpart_type   r;
      logic [RW-1:0] num;
      logic [RW-1:0] lim;
      logic [64:0]   qv;
      num   = RW'(p.mag) << FRAC_BITS;
      lim   = RW'(d) << (QW - 1);
      qv    = {1'b0, p.mag >> FRAC_BITS} + 65'(p.mag[FRAC_BITS-1]);
      r     = '0;
      r.neg = p.neg;
      case (f) inside
         FUNC_ADD, FUNC_SUB: begin
            r.quo = QW'(p.mag);
         end
         FUNC_MUL, FUNC_SCALE: begin
            r.quo = QW'(qv);
            r.ovf = |qv[64:QW-1];
         end
         FUNC_DIVC, FUNC_DIVR: begin
            if (dv) begin
               r.rem = num;
               r.ovf = (num >= lim);
            end
         end
         default: begin
            r.neg = 1'b0;
         end
      endcase
      return r;
   endfunction

   // Test divisor and compare against tolerance, then set up the parts
   always_comb begin
      thr    = (in_data.func == FUNC_DIVC) ? (64'(tolerance) << FRAC_BITS)
                                           : 64'(tolerance);
      is_dv  = (in_data.func == FUNC_DIVC) || (in_data.func == FUNC_DIVR);
      err    = is_dv && ((in_data.dvsr == '0) || (in_data.dvsr < thr));
      data_in.is_div = is_dv && !err;
      data_in.err    = err;
      data_in.eq     = (in_data.func == FUNC_CMP) &&
                       (in_data.re.mag <= 64'(tolerance)) &&
                       (in_data.im.mag <= 64'(tolerance));
      data_in.dvsr   = in_data.dvsr;
      data_in.re     = prep_part(in_data.re, in_data.func, data_in.is_div, in_data.dvsr);
      data_in.im     = prep_part(in_data.im, in_data.func, data_in.is_div, in_data.dvsr);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

FILE: hw/rtl/cna_div_stage.sv
// One restoring-division stage: resolves one quotient bit of both parts.
module cna_div_stage #(
   parameter int SHIFT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  cna_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output cna_pkg::div_type out_data
);
   import cna_pkg::*;

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;

   function automatic dpart_type step(dpart_type p, logic dv, logic [63:0] d);
      dpart_type   r;
      logic [RW-1:0] t;
      r = p;
      t = RW'(d) << SHIFT;
      if (dv && (p.rem >= t)) begin
         r.rem        = p.rem - t;
         r.quo[SHIFT] = 1'b1;
      end
      return r;
   endfunction

   // Subtract the shifted divisor where it fits
   always_comb begin
      data_in    = in_data;
      data_in.re = step(in_data.re, in_data.is_div, in_data.dvsr);
      data_in.im = step(in_data.im, in_data.is_div, in_data.dvsr);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

FILE: hw/rtl/cna_round.sv
// Last stage: round quotients, saturate, and hold the result register.
module cna_round (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  cna_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output cna_pkg::rsp_type out_data
);
   import cna_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;
   rsp_type data_in;
   logic    sat_re;
   logic    sat_im;

   // Round half away from zero, then clip to the 32-bit range
   function automatic logic [32:0] fin(dpart_type p, logic dv, logic [63:0] d);
      logic          rnd;
      logic [QW-1:0] q;
      logic          sat;
      logic [31:0]   v;
      rnd = dv && !p.ovf && ({p.rem[63:0], 1'b0} >= {1'b0, d});
      q   = p.quo + QW'(rnd);
      sat = p.ovf || (p.neg ? (q > Q_MAX_NEG) : (q > Q_MAX_POS));
      if (sat) begin
         v = p.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         v = p.neg ? (~q[31:0] + 32'd1) : q[31:0];
      end
      return {sat, v};
   endfunction

   always_comb begin
      {sat_re, data_in.res_real} = fin(in_data.re, in_data.is_div, in_data.dvsr);
      {sat_im, data_in.res_imag} = fin(in_data.im, in_data.is_div, in_data.dvsr);
      data_in.equal_flag = in_data.eq;
      data_in.div_error  = in_data.err;
      data_in.saturated  = sat_re | sat_im;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

FILE: hw/rtl/complex_number_alu.sv
// Top level of the pipelined complex arithmetic unit.
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  req_bus  | in        | func, a_real, a_imag, b_real, b_imag, scalar
//  rsp_bus  | out       | res_real, res_imag, equal_flag, div_error, saturated
//  csr_bus  | in        | tolerance (31 bits, reset 1)
//
// One transaction enters per cycle while the pipeline has room; each result
// passes through products, combine, test/setup, 33 restoring divider stages
// (one quotient bit each) and a round/saturate output register.
// Every stage holds its own valid bit and moves when the stage ahead has room,
// so bubbles collapse; a stalled result holds the chain behind it, and new
// requests stall only once all 37 stages are full.
// Synchronous reset empties the pipeline and sets tolerance to 1.
module complex_number_alu #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   cna_req_if.sink   req_bus,
   cna_rsp_if.source rsp_bus,
   cna_csr_if.sink   csr_bus
);
   import cna_pkg::*;

   localparam int NDIV = QW - 1;

   logic [30:0] tol_ff;
   op_type      req_data;

   logic     a_valid, a_ready;
   prod_type a_data;
   logic     b_valid, b_ready;
   comb_type b_data;
   logic     d_valid [0:NDIV];
   logic     d_ready [0:NDIV];
   div_type  d_data  [0:NDIV];
   rsp_type  rsp_data;

   // Tolerance register
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= 31'd1;
      end else if (csr_bus.valid) begin
         tol_ff <= csr_bus.tolerance;
      end
   end

   always_comb begin
      req_data.func   = req_bus.func;
      req_data.a_real = req_bus.a_real;
      req_data.a_imag = req_bus.a_imag;
      req_data.b_real = req_bus.b_real;
      req_data.b_imag = req_bus.b_imag;
      req_data.scalar = req_bus.scalar;
   end

   cna_mult u_mult (
      .clock, .reset,
      .in_valid (req_bus.valid), .in_ready (req_bus.ready), .in_data (req_data),
      .out_valid (a_valid), .out_ready (a_ready), .out_data (a_data)
   );

   cna_combine u_combine (
      .clock, .reset,
      .in_valid (a_valid), .in_ready (a_ready), .in_data (a_data),
      .out_valid (b_valid), .out_ready (b_ready), .out_data (b_data)
   );

   cna_prep #(.FRAC_BITS (FRAC_BITS)) u_prep (
      .clock, .reset, .tolerance (tol_ff),
      .in_valid (b_valid), .in_ready (b_ready), .in_data (b_data),
      .out_valid (d_valid[0]), .out_ready (d_ready[0]), .out_data (d_data[0])
   );

   // Divider chain, most significant quotient bit first
   for (genvar i = 0; i < NDIV; i++) begin : g_div
      cna_div_stage #(.SHIFT (NDIV - 1 - i)) u_stage (
         .clock, .reset,
         .in_valid (d_valid[i]), .in_ready (d_ready[i]), .in_data (d_data[i]),
         .out_valid (d_valid[i+1]), .out_ready (d_ready[i+1]), .out_data (d_data[i+1])
      );
   end

   cna_round u_round (
      .clock, .reset,
      .in_valid (d_valid[NDIV]), .in_ready (d_ready[NDIV]), .in_data (d_data[NDIV]),
      .out_valid (rsp_bus.valid), .out_ready (rsp_bus.ready), .out_data (rsp_data)
   );

   assign rsp_bus.res_real   = rsp_data.res_real;
   assign rsp_bus.res_imag   = rsp_data.res_imag;
   assign rsp_bus.equal_flag = rsp_data.equal_flag;
   assign rsp_bus.div_error  = rsp_data.div_error;
   assign rsp_bus.saturated  = rsp_data.saturated;

   // Checks
   a_tol_write: assert property (@(posedge clock) disable iff (reset)
      (csr_bus.valid && csr_bus.ready) |=> (tol_ff == $past(csr_bus.tolerance)))
      else $error("tolerance register missed a write");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.div_error) |->
      (rsp_bus.res_real == 32'sd0 && rsp_bus.res_imag == 32'sd0 && !rsp_bus.saturated))
      else $error("divide error with nonzero result");

   a_eq_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.equal_flag) |->
      (!rsp_bus.div_error && !rsp_bus.saturated && rsp_bus.res_real == 32'sd0))
      else $error("compare result carries other status");
endmodule
